>>> hw/rtl/numeric_literal_parser_macros.svh
// ----------------------------------------------------------------------------
// numeric literal parser assertion macros
// shared concurrent assertion forms, clocked on clk_i, held off during reset
// ----------------------------------------------------------------------------
`ifndef NUMERIC_LITERAL_PARSER_MACROS_SVH
`define NUMERIC_LITERAL_PARSER_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define NLP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("numeric literal parser: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define NLP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("numeric literal parser: next-cycle check failed");

`endif

>>> hw/rtl/nlp_pkg.sv
// ----------------------------------------------------------------------------
// nlp_pkg
// types and constants shared by the numeric literal parser
// ----------------------------------------------------------------------------
`default_nettype none

package nlp_pkg;

  localparam int unsigned CHAR_W  = 21;
  localparam int unsigned VALUE_W = 63;

  // radix of the lexeme
  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_BIN = 2'd2
  } nlp_radix_e;

  // scan phase within the lexeme
  typedef enum logic [1:0] {
    PH_DIGITS = 2'd0,
    PH_SUFFIX = 2'd1,
    PH_CLOSED = 2'd2
  } nlp_phase_e;

  // parse status; multi-dot is reported over overflow, and overflow over bad format
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_OVERFLOW   = 2'd1,
    ST_BAD_FORMAT = 2'd2,
    ST_MULTI_DOT  = 2'd3
  } nlp_status_e;

  // code points of interest
  localparam logic [CHAR_W-1:0] CH_0      = 21'h00030;
  localparam logic [CHAR_W-1:0] CH_1      = 21'h00031;
  localparam logic [CHAR_W-1:0] CH_9      = 21'h00039;
  localparam logic [CHAR_W-1:0] CH_LO_A   = 21'h00061;
  localparam logic [CHAR_W-1:0] CH_LO_F   = 21'h00066;
  localparam logic [CHAR_W-1:0] CH_UP_A   = 21'h00041;
  localparam logic [CHAR_W-1:0] CH_UP_F   = 21'h00046;
  localparam logic [CHAR_W-1:0] CH_LO_X   = 21'h00078;
  localparam logic [CHAR_W-1:0] CH_UP_X   = 21'h00058;
  localparam logic [CHAR_W-1:0] CH_LO_B   = 21'h00062;
  localparam logic [CHAR_W-1:0] CH_UP_B   = 21'h00042;
  localparam logic [CHAR_W-1:0] CH_DOT    = 21'h0002E;
  localparam logic [CHAR_W-1:0] CH_ARDOT  = 21'h0066B;
  localparam logic [CHAR_W-1:0] CH_EXP    = 21'h00623;
  localparam logic [CHAR_W-1:0] CH_AR0    = 21'h00660;
  localparam logic [CHAR_W-1:0] CH_AR9    = 21'h00669;
  localparam logic [CHAR_W-1:0] CH_TAH    = 21'h00637;
  localparam logic [CHAR_W-1:0] CH_GHAIN  = 21'h0063A;
  localparam logic [CHAR_W-1:0] CH_HAH    = 21'h0062D;

  // scan state carried from one character to the next
  typedef struct packed {
    nlp_phase_e         phase;
    logic [VALUE_W-1:0] accum;
    nlp_radix_e         radix;
    logic [1:0]         char_index;
    logic               first_is_zero;
    logic               digit_seen;
    logic               overflow_seen;
    logic               dot_seen;
    logic               multi_dot_seen;
    logic               exp_seen;
    logic [1:0]         long_marks;
    logic               unsigned_seen;
    logic               hah_seen;
    logic [1:0]         suffix_used;
    logic               format_bad;
  } nlp_state_t;

  localparam nlp_state_t STATE_RESET = '{
    phase:          PH_DIGITS,
    accum:          '0,
    radix:          RADIX_DEC,
    char_index:     2'd0,
    first_is_zero:  1'b0,
    digit_seen:     1'b0,
    overflow_seen:  1'b0,
    dot_seen:       1'b0,
    multi_dot_seen: 1'b0,
    exp_seen:       1'b0,
    long_marks:     2'd0,
    unsigned_seen:  1'b0,
    hah_seen:       1'b0,
    suffix_used:    2'd0,
    format_bad:     1'b0
  };

  // one finished lexeme
  typedef struct packed {
    logic [VALUE_W-1:0] value;
    nlp_status_e        status;
    logic               real_kind;
    nlp_radix_e         radix;
    logic               unsigned_mark;
    logic [1:0]         long_count;
    logic               float_mark;
  } nlp_result_t;

endpackage

`default_nettype wire

>>> hw/rtl/nlp_if.sv
// ----------------------------------------------------------------------------
// nlp channel interfaces
// valid/ready channels for lexeme characters and parsed literals
// ----------------------------------------------------------------------------
`default_nettype none

interface nlp_char_if;
  logic                        valid;
  logic                        ready;
  logic [nlp_pkg::CHAR_W-1:0]  char_code;
  logic                        last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface nlp_lit_if;
  logic                        valid;
  logic                        ready;
  logic [nlp_pkg::VALUE_W-1:0] literal_value;
  logic [1:0]                  parse_status;
  logic                        literal_kind;
  logic [1:0]                  radix_code;
  logic                        unsigned_mark;
  logic [1:0]                  long_count;
  logic                        float_mark;

  modport source (output valid, output literal_value, output parse_status,
                  output literal_kind, output radix_code, output unsigned_mark,
                  output long_count, output float_mark, input ready);
  modport sink   (input valid, input literal_value, input parse_status,
                  input literal_kind, input radix_code, input unsigned_mark,
                  input long_count, input float_mark, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/numeric_literal_parser.sv
// order: a transferred character is held in the input register and scanned from there;
//   a literal is loaded into the result register when its final character is scanned
// throughput: one character per cycle, set by the single scan step between the input and
//   result registers; a final character waits on a full result register not yet taken
// reset: asynchronous, active low; clears the valid bits of both channel registers and the scan state
`default_nettype none

`include "numeric_literal_parser_macros.svh"

// ----------------------------------------------------------------------------
// numeric_literal_parser
// parses one numeric lexeme per literal: radix prefix, digits, suffixes, status
// ----------------------------------------------------------------------------
module numeric_literal_parser (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  nlp_char_if.sink   in_i,
  nlp_lit_if.source  out_o
);

  logic                        in_valid_q;
  logic [nlp_pkg::CHAR_W-1:0]  in_char_q;
  logic                        in_last_q;
  logic                        step_go;
  logic                        in_take;

  nlp_pkg::nlp_state_t         state_q;
  nlp_pkg::nlp_state_t         state_d;
  nlp_pkg::nlp_result_t        result_d;
  nlp_pkg::nlp_result_t        result_q;
  logic                        out_valid_q;
  logic                        out_valid_d;
  logic                        payload_clear;

  // a character only waits when it closes a literal and the result register is full and not being taken
  assign step_go  = in_valid_q && (!in_last_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || step_go;
  assign in_take  = in_i.valid && in_i.ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_char_q <= in_i.char_code;
      in_last_q <= in_i.last_char;
    end
  end

  // scan step
  nlp_step u_step (
    .state_i     (state_q),
    .char_code_i (in_char_q),
    .last_char_i (in_last_q),
    .state_o     (state_d),
    .result_o    (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nlp_pkg::STATE_RESET;
    end else if (step_go) begin
      state_q <= state_d;
    end
  end

  // result register
  always_comb begin
    if (step_go && in_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && in_last_q) begin
      result_q <= result_d;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.literal_value = result_q.value;
  assign out_o.parse_status  = result_q.status;
  assign out_o.literal_kind  = result_q.real_kind;
  assign out_o.radix_code    = result_q.radix;
  assign out_o.unsigned_mark = result_q.unsigned_mark;
  assign out_o.long_count    = result_q.long_count;
  assign out_o.float_mark    = result_q.float_mark;

  // value and suffix fields all zero
  assign payload_clear = result_q.value == '0 && result_q.long_count == 2'd0 &&
                         !result_q.unsigned_mark && !result_q.float_mark;

  // checks
  `NLP_ASSERT_NEXT(a_last_loads_result, step_go && in_last_q, out_valid_q)
  `NLP_ASSERT_NEXT(a_last_clears_scan, step_go && in_last_q, state_q == nlp_pkg::STATE_RESET)
  `NLP_ASSERT_SAME(a_error_no_payload, out_valid_q && result_q.status != nlp_pkg::ST_OK, payload_clear)
  `NLP_ASSERT_SAME(a_real_no_value, out_valid_q && result_q.real_kind, result_q.value == '0)
  `NLP_ASSERT_SAME(a_long_bound, out_valid_q, result_q.long_count != 2'd3)

endmodule

`default_nettype wire

>>> hw/rtl/nlp_step.sv
// ----------------------------------------------------------------------------
// nlp_step
// one character of scan: prefix, digit accumulate, suffix and result build
// ----------------------------------------------------------------------------
`default_nettype none

module nlp_step (
  input  nlp_pkg::nlp_state_t          state_i,
  input  logic [nlp_pkg::CHAR_W-1:0]   char_code_i,
  input  logic                         last_char_i,
  output nlp_pkg::nlp_state_t          state_o,
  output nlp_pkg::nlp_result_t         result_o
);

  logic                         dig_ok;
  logic [3:0]                   dig_val;
  logic [nlp_pkg::VALUE_W+4:0]  acc_ext;
  logic [nlp_pkg::VALUE_W+4:0]  scaled;
  logic [nlp_pkg::VALUE_W+4:0]  sum_ext;
  logic                         acc_ovf;
  logic                         prefix_pos;
  logic                         prefix;
  logic                         is_real;
  nlp_pkg::nlp_status_e         status;
  logic                         good_int;
  nlp_pkg::nlp_state_t          s;

  // suffix character handling
  function automatic nlp_pkg::nlp_state_t suffix_step(nlp_pkg::nlp_state_t st,
                                                      logic [nlp_pkg::CHAR_W-1:0] c);
    nlp_pkg::nlp_state_t r;
    r = st;
    if (st.suffix_used == 2'd3) begin
      r.format_bad = 1'b1;
      r.phase      = nlp_pkg::PH_CLOSED;
    end else if (c == nlp_pkg::CH_TAH && st.long_marks < 2'd2) begin
      r.long_marks  = st.long_marks + 2'd1;
      r.suffix_used = st.suffix_used + 2'd1;
    end else if (c == nlp_pkg::CH_GHAIN && !st.unsigned_seen) begin
      r.unsigned_seen = 1'b1;
      r.suffix_used   = st.suffix_used + 2'd1;
    end else if (c == nlp_pkg::CH_HAH) begin
      r.hah_seen    = 1'b1;
      r.suffix_used = st.suffix_used + 2'd1;
      r.phase       = nlp_pkg::PH_CLOSED;
    end else begin
      r.format_bad = 1'b1;
      r.phase      = nlp_pkg::PH_CLOSED;
    end
    return r;
  endfunction

  // digit decode in the current radix
  always_comb begin
    dig_ok  = 1'b0;
    dig_val = 4'd0;
    if (state_i.radix == nlp_pkg::RADIX_BIN) begin
      if (char_code_i == nlp_pkg::CH_0 || char_code_i == nlp_pkg::CH_1) begin
        dig_ok  = 1'b1;
        dig_val = 4'(char_code_i - nlp_pkg::CH_0);
      end
    end else if (char_code_i >= nlp_pkg::CH_0 && char_code_i <= nlp_pkg::CH_9) begin
      dig_ok  = 1'b1;
      dig_val = 4'(char_code_i - nlp_pkg::CH_0);
    end else if (state_i.radix == nlp_pkg::RADIX_HEX) begin
      if (char_code_i >= nlp_pkg::CH_LO_A && char_code_i <= nlp_pkg::CH_LO_F) begin
        dig_ok  = 1'b1;
        dig_val = 4'(char_code_i - nlp_pkg::CH_LO_A) + 4'd10;
      end else if (char_code_i >= nlp_pkg::CH_UP_A && char_code_i <= nlp_pkg::CH_UP_F) begin
        dig_ok  = 1'b1;
        dig_val = 4'(char_code_i - nlp_pkg::CH_UP_A) + 4'd10;
      end
    end else if (char_code_i >= nlp_pkg::CH_AR0 && char_code_i <= nlp_pkg::CH_AR9) begin
      dig_ok  = 1'b1;
      dig_val = 4'(char_code_i - nlp_pkg::CH_AR0);
    end
  end

  // multiply-add by the radix as shifts, overflow past the signed 64-bit maximum
  always_comb begin
    acc_ext = {5'd0, state_i.accum};
    unique case (state_i.radix)
      nlp_pkg::RADIX_HEX: scaled = acc_ext << 4;
      nlp_pkg::RADIX_BIN: scaled = acc_ext << 1;
      default:            scaled = (acc_ext << 3) + (acc_ext << 1);
    endcase
    sum_ext = scaled + {{(nlp_pkg::VALUE_W + 1){1'b0}}, dig_val};
    acc_ovf = |sum_ext[nlp_pkg::VALUE_W+4:nlp_pkg::VALUE_W];
  end

  // state update for one character
  always_comb begin
    s          = state_i;
    prefix     = 1'b0;
    prefix_pos = state_i.char_index == 2'd1 && state_i.first_is_zero &&
                 state_i.phase == nlp_pkg::PH_DIGITS && state_i.radix == nlp_pkg::RADIX_DEC;

    // radix prefix after a leading zero
    if (prefix_pos) begin
      if (char_code_i == nlp_pkg::CH_LO_X || char_code_i == nlp_pkg::CH_UP_X) begin
        s.radix = nlp_pkg::RADIX_HEX;
        prefix  = 1'b1;
      end else if (char_code_i == nlp_pkg::CH_LO_B || char_code_i == nlp_pkg::CH_UP_B) begin
        s.radix = nlp_pkg::RADIX_BIN;
        prefix  = 1'b1;
      end
    end
    if (prefix) begin
      s.accum      = '0;
      s.digit_seen = 1'b0;
    end
    if (state_i.char_index == 2'd0 && char_code_i == nlp_pkg::CH_0) begin
      s.first_is_zero = 1'b1;
    end

    if (!prefix) begin
      // separators and exponent marker
      if (state_i.radix == nlp_pkg::RADIX_DEC && !state_i.exp_seen) begin
        if (char_code_i == nlp_pkg::CH_DOT || char_code_i == nlp_pkg::CH_ARDOT) begin
          if (state_i.dot_seen) begin
            s.multi_dot_seen = 1'b1;
          end
          s.dot_seen = 1'b1;
        end else if (char_code_i == nlp_pkg::CH_EXP) begin
          s.exp_seen = 1'b1;
        end
      end else if (state_i.radix == nlp_pkg::RADIX_HEX && char_code_i == nlp_pkg::CH_EXP) begin
        s.exp_seen = 1'b1;
      end

      // digits, then suffix, then anything left over
      if (state_i.phase == nlp_pkg::PH_DIGITS) begin
        if (dig_ok) begin
          if (!state_i.overflow_seen) begin
            if (acc_ovf) begin
              s.overflow_seen = 1'b1;
            end else begin
              s.accum = sum_ext[nlp_pkg::VALUE_W-1:0];
            end
            s.digit_seen = 1'b1;
          end
        end else if (!state_i.overflow_seen) begin
          s.phase = nlp_pkg::PH_SUFFIX;
          s       = suffix_step(s, char_code_i);
        end
      end else if (state_i.phase == nlp_pkg::PH_SUFFIX) begin
        s = suffix_step(s, char_code_i);
      end else begin
        s.format_bad = 1'b1;
      end
    end

    if (state_i.char_index != 2'd2) begin
      s.char_index = state_i.char_index + 2'd1;
    end

    // result from the updated state
    is_real = (s.radix == nlp_pkg::RADIX_DEC && (s.dot_seen || s.exp_seen)) ||
              (s.radix == nlp_pkg::RADIX_HEX && s.exp_seen);
    if (s.radix == nlp_pkg::RADIX_DEC && s.multi_dot_seen) begin
      status = nlp_pkg::ST_MULTI_DOT;
    end else if (s.overflow_seen) begin
      status = nlp_pkg::ST_OVERFLOW;
    end else if (is_real) begin
      status = nlp_pkg::ST_OK;
    end else if (s.format_bad || !s.digit_seen) begin
      status = nlp_pkg::ST_BAD_FORMAT;
    end else begin
      status = nlp_pkg::ST_OK;
    end
    good_int = status == nlp_pkg::ST_OK && !is_real;

    result_o.value         = good_int ? s.accum : '0;
    result_o.status        = status;
    result_o.real_kind     = is_real;
    result_o.radix         = s.radix;
    result_o.unsigned_mark = good_int && s.unsigned_seen;
    result_o.long_count    = good_int ? s.long_marks : 2'd0;
    result_o.float_mark    = good_int && s.hah_seen;

    // scan state starts afresh after the final character
    state_o = last_char_i ? nlp_pkg::STATE_RESET : s;
  end

endmodule

`default_nettype wire

>>> bench/tb_numeric_literal_parser.sv
// ----------------------------------------------------------------------------
// tb_numeric_literal_parser
// streams numeric lexemes one code point per transfer into the parser and
// checks every parsed literal against a behavioural scan model held in a
// scoreboard; both channels stall at random, with one stretch held steady
// ----------------------------------------------------------------------------
`default_nettype none

typedef logic [nlp_pkg::CHAR_W-1:0] code_t;
typedef code_t lexeme_t[$];

// scan model of the parser and the queue of literals it predicts
class literal_scoreboard;
  localparam logic [63:0] VALUE_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

  nlp_pkg::nlp_result_t  expected_q[$];
  int unsigned           fail_count;

  nlp_pkg::nlp_phase_e   phase;
  logic [62:0]           accum;
  nlp_pkg::nlp_radix_e   radix;
  logic [1:0]            pos;
  logic                  lead_zero;
  logic                  have_digit;
  logic                  ovf;
  logic                  dot;
  logic                  multi_dot;
  logic                  exp;
  logic [1:0]            tah_n;
  logic                  ghain;
  logic                  hah;
  logic [1:0]            suffix_n;
  logic                  bad;

  function new();
    fail_count = 0;
    clear_scan();
  endfunction

  function void clear_scan();
    phase      = nlp_pkg::PH_DIGITS;
    accum      = '0;
    radix      = nlp_pkg::RADIX_DEC;
    pos        = 2'd0;
    lead_zero  = 1'b0;
    have_digit = 1'b0;
    ovf        = 1'b0;
    dot        = 1'b0;
    multi_dot  = 1'b0;
    exp        = 1'b0;
    tah_n      = 2'd0;
    ghain      = 1'b0;
    hah        = 1'b0;
    suffix_n   = 2'd0;
    bad        = 1'b0;
  endfunction

  // value of c as a digit of the current radix, -1 when it is none
  function int digit_value(code_t c);
    if (radix == nlp_pkg::RADIX_BIN)
      return (c == nlp_pkg::CH_0 || c == nlp_pkg::CH_1) ? int'(c - nlp_pkg::CH_0) : -1;
    if (c >= nlp_pkg::CH_0 && c <= nlp_pkg::CH_9) return int'(c - nlp_pkg::CH_0);
    if (radix == nlp_pkg::RADIX_HEX) begin
      if (c >= nlp_pkg::CH_LO_A && c <= nlp_pkg::CH_LO_F) return int'(c - nlp_pkg::CH_LO_A) + 10;
      if (c >= nlp_pkg::CH_UP_A && c <= nlp_pkg::CH_UP_F) return int'(c - nlp_pkg::CH_UP_A) + 10;
      return -1;
    end
    if (c >= nlp_pkg::CH_AR0 && c <= nlp_pkg::CH_AR9) return int'(c - nlp_pkg::CH_AR0);
    return -1;
  endfunction

  // one character after the digits: long, unsigned and float marks
  function void take_suffix(code_t c);
    if (suffix_n >= 2'd3) begin
      bad   = 1'b1;
      phase = nlp_pkg::PH_CLOSED;
    end else if (c == nlp_pkg::CH_TAH && tah_n < 2'd2) begin
      tah_n++;
      suffix_n++;
    end else if (c == nlp_pkg::CH_GHAIN && !ghain) begin
      ghain = 1'b1;
      suffix_n++;
    end else if (c == nlp_pkg::CH_HAH) begin
      hah   = 1'b1;
      suffix_n++;
      phase = nlp_pkg::PH_CLOSED;
    end else begin
      bad   = 1'b1;
      phase = nlp_pkg::PH_CLOSED;
    end
  endfunction

  // advance the scan by one transferred character, predict on the last one
  function void note_char(code_t c, logic fin);
    logic                  is_prefix;
    int                    d;
    logic [63:0]           base;
    logic [63:0]           wide;
    logic                  is_real;
    logic                  good;
    nlp_pkg::nlp_status_e  st;
    nlp_pkg::nlp_result_t  r;
    is_prefix = 1'b0;
    // radix prefix right after a leading zero
    if (pos == 2'd1 && lead_zero && phase == nlp_pkg::PH_DIGITS &&
        radix == nlp_pkg::RADIX_DEC) begin
      if (c == nlp_pkg::CH_LO_X || c == nlp_pkg::CH_UP_X) begin
        radix     = nlp_pkg::RADIX_HEX;
        is_prefix = 1'b1;
      end else if (c == nlp_pkg::CH_LO_B || c == nlp_pkg::CH_UP_B) begin
        radix     = nlp_pkg::RADIX_BIN;
        is_prefix = 1'b1;
      end
      if (is_prefix) begin
        accum      = '0;
        have_digit = 1'b0;
      end
    end
    if (pos == 2'd0 && c == nlp_pkg::CH_0) lead_zero = 1'b1;

    if (!is_prefix) begin
      // separators and exponent marker
      if (radix == nlp_pkg::RADIX_DEC && !exp) begin
        if (c == nlp_pkg::CH_DOT || c == nlp_pkg::CH_ARDOT) begin
          if (dot) multi_dot = 1'b1;
          dot = 1'b1;
        end else if (c == nlp_pkg::CH_EXP) begin
          exp = 1'b1;
        end
      end else if (radix == nlp_pkg::RADIX_HEX && c == nlp_pkg::CH_EXP) begin
        exp = 1'b1;
      end

      // digits, then suffixes, then anything left over
      if (phase == nlp_pkg::PH_DIGITS) begin
        d = digit_value(c);
        if (d >= 0) begin
          if (!ovf) begin
            base = (radix == nlp_pkg::RADIX_HEX) ? 64'd16 :
                   (radix == nlp_pkg::RADIX_BIN) ? 64'd2 : 64'd10;
            wide = {1'b0, accum};
            if (wide > (VALUE_LIMIT - 64'(d)) / base) begin
              ovf = 1'b1;
            end else begin
              wide  = wide * base + 64'(d);
              accum = wide[62:0];
            end
            have_digit = 1'b1;
          end
        end else if (!ovf) begin
          phase = nlp_pkg::PH_SUFFIX;
          take_suffix(c);
        end
      end else if (phase == nlp_pkg::PH_SUFFIX) begin
        take_suffix(c);
      end else begin
        bad = 1'b1;
      end
    end
    if (pos < 2'd2) pos++;

    if (!fin) return;

    // status in priority order
    is_real = (radix == nlp_pkg::RADIX_DEC && (dot || exp)) ||
              (radix == nlp_pkg::RADIX_HEX && exp);
    if (radix == nlp_pkg::RADIX_DEC && multi_dot) st = nlp_pkg::ST_MULTI_DOT;
    else if (ovf)                                  st = nlp_pkg::ST_OVERFLOW;
    else if (is_real)                              st = nlp_pkg::ST_OK;
    else if (bad || !have_digit)                   st = nlp_pkg::ST_BAD_FORMAT;
    else                                           st = nlp_pkg::ST_OK;
    good = (st == nlp_pkg::ST_OK) && !is_real;

    r.value         = good ? accum : '0;
    r.status        = st;
    r.real_kind     = is_real;
    r.radix         = radix;
    r.unsigned_mark = good && ghain;
    r.long_count    = good ? tah_n : 2'd0;
    r.float_mark    = good && hah;
    expected_q.push_back(r);
    clear_scan();
  endfunction

  // compare a transferred literal with the oldest prediction
  function void check_literal(nlp_pkg::nlp_result_t got);
    nlp_pkg::nlp_result_t want;
    if (expected_q.size() == 0) begin
      $error("literal transferred with none predicted: value %0d status %0d",
             got.value, got.status);
      fail_count++;
      return;
    end
    want = expected_q.pop_front();
    if (got.value !== want.value) begin
      $error("literal_value: expected %0d, actual %0d", want.value, got.value);
      fail_count++;
    end
    if (got.status !== want.status) begin
      $error("parse_status: expected %0d, actual %0d", want.status, got.status);
      fail_count++;
    end
    if (got.real_kind !== want.real_kind) begin
      $error("literal_kind: expected %0d, actual %0d", want.real_kind, got.real_kind);
      fail_count++;
    end
    if (got.radix !== want.radix) begin
      $error("radix_code: expected %0d, actual %0d", want.radix, got.radix);
      fail_count++;
    end
    if (got.unsigned_mark !== want.unsigned_mark) begin
      $error("unsigned_mark: expected %0d, actual %0d", want.unsigned_mark,
             got.unsigned_mark);
      fail_count++;
    end
    if (got.long_count !== want.long_count) begin
      $error("long_count: expected %0d, actual %0d", want.long_count, got.long_count);
      fail_count++;
    end
    if (got.float_mark !== want.float_mark) begin
      $error("float_mark: expected %0d, actual %0d", want.float_mark, got.float_mark);
      fail_count++;
    end
  endfunction

  function int unsigned pending();
    return expected_q.size();
  endfunction
endclass

module tb_numeric_literal_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CHAR_TARGET  = 1850;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned IDLE_PCT     = 8;

  logic              clk_i;
  logic              rst_ni;
  logic              steady;
  int unsigned       chars_sent;
  literal_scoreboard sb;

  nlp_char_if char_ch ();
  nlp_lit_if  lit_ch ();

  numeric_literal_parser dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_ch),
    .out_o  (lit_ch)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // literal side back-pressure
  initial begin
    lit_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      lit_ch.ready <= rst_ni && (steady || $urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // character transfers feed the scan model
  always @(posedge clk_i) begin
    if (rst_ni && char_ch.valid && char_ch.ready)
      sb.note_char(char_ch.char_code, char_ch.last_char);
  end

  // literal transfers are checked
  always @(posedge clk_i) begin : lit_monitor
    nlp_pkg::nlp_result_t got;
    if (rst_ni && lit_ch.valid && lit_ch.ready) begin
      got.value         = lit_ch.literal_value;
      got.status        = nlp_pkg::nlp_status_e'(lit_ch.parse_status);
      got.real_kind     = lit_ch.literal_kind;
      got.radix         = nlp_pkg::nlp_radix_e'(lit_ch.radix_code);
      got.unsigned_mark = lit_ch.unsigned_mark;
      got.long_count    = lit_ch.long_count;
      got.float_mark    = lit_ch.float_mark;
      sb.check_literal(got);
    end
  end

  // watchdog on cycles without any transfer
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((char_ch.valid && char_ch.ready) || (lit_ch.valid && lit_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  // one character, with random idle cycles ahead of it
  task automatic send_char(input code_t code, input logic fin);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      char_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    char_ch.valid     <= 1'b1;
    char_ch.char_code <= code;
    char_ch.last_char <= fin;
    @(posedge clk_i);
    while (!char_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    chars_sent++;
  endtask

  task automatic send_lexeme(input lexeme_t lex);
    foreach (lex[i]) send_char(lex[i], i == lex.size() - 1);
  endtask

  // a code point off the usual path: full range, ascii or a special character
  function automatic code_t odd_code();
    case ($urandom_range(0, 2))
      0: return code_t'($urandom_range(0, 21'h10FFFF));
      1: return code_t'($urandom_range(0, 127));
      default: begin
        case ($urandom_range(0, 9))
          0: return nlp_pkg::CH_TAH;
          1: return nlp_pkg::CH_GHAIN;
          2: return nlp_pkg::CH_HAH;
          3: return nlp_pkg::CH_EXP;
          4: return nlp_pkg::CH_DOT;
          5: return nlp_pkg::CH_ARDOT;
          6: return nlp_pkg::CH_0;
          7: return nlp_pkg::CH_LO_X;
          8: return nlp_pkg::CH_UP_B;
          default: return code_t'($urandom_range(nlp_pkg::CH_AR0, nlp_pkg::CH_AR9));
        endcase
      end
    endcase
  endfunction

  // random lexeme: mostly well formed literals, some broken ones and noise
  function automatic void make_lexeme(output lexeme_t lex);
    nlp_pkg::nlp_radix_e rdx;
    int unsigned         sel;
    int unsigned         script;
    logic [63:0]         v;
    string               digits;
    byte                 ch;
    code_t               c;
    lexeme_t             suf;
    int unsigned         n;
    lex = {};
    if ($urandom_range(0, 99) < 8) begin
      n = $urandom_range(1, 4);
      repeat (n) lex.push_back(odd_code());
      return;
    end

    // radix and prefix
    sel = $urandom_range(0, 9);
    rdx = (sel < 5) ? nlp_pkg::RADIX_DEC :
          (sel < 8) ? nlp_pkg::RADIX_HEX : nlp_pkg::RADIX_BIN;
    if (rdx == nlp_pkg::RADIX_HEX)
      lex = {nlp_pkg::CH_0, $urandom_range(0, 1) ? nlp_pkg::CH_LO_X : nlp_pkg::CH_UP_X};
    if (rdx == nlp_pkg::RADIX_BIN)
      lex = {nlp_pkg::CH_0, $urandom_range(0, 1) ? nlp_pkg::CH_LO_B : nlp_pkg::CH_UP_B};

    // value, kept short for binary most of the time
    sel = (rdx == nlp_pkg::RADIX_BIN && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: v = 64'($urandom_range(0, 999));
      4, 5:       v = {$urandom, $urandom} >> $urandom_range(1, 63);
      6:          v = {$urandom, $urandom} >> 1;
      7:          v = 64'h7FFF_FFFF_FFFF_FFFF;
      8:          v = 64'h8000_0000_0000_0000;
      default:    v = {$urandom, $urandom} | 64'h8000_0000_0000_0000;
    endcase
    case (rdx)
      nlp_pkg::RADIX_HEX: digits = $sformatf("%0h", v);
      nlp_pkg::RADIX_BIN: digits = $sformatf("%0b", v);
      default:            digits = $sformatf("%0d", v);
    endcase
    if ($urandom_range(0, 19) == 0) digits = "";
    else if (rdx == nlp_pkg::RADIX_DEC && $urandom_range(0, 7) == 0) lex.push_back(nlp_pkg::CH_0);

    // digits: upper or lower case hex, ascii or arabic-indic decimal
    script = $urandom_range(0, 3);
    for (int i = 0; i < digits.len(); i++) begin
      ch = digits[i];
      c  = code_t'(ch);
      if (rdx == nlp_pkg::RADIX_HEX && ch >= 8'h61 && $urandom_range(0, 1))
        c = code_t'(ch - 8'h20);
      if (rdx == nlp_pkg::RADIX_DEC && (script == 2 || (script == 3 && $urandom_range(0, 1))))
        c = nlp_pkg::CH_AR0 + code_t'(ch - 8'h30);
      lex.push_back(c);
    end

    // real forms: separators and exponent markers with fraction digits
    if (rdx == nlp_pkg::RADIX_DEC && $urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        case ($urandom_range(0, 2))
          0: lex.push_back(nlp_pkg::CH_DOT);
          1: lex.push_back(nlp_pkg::CH_ARDOT);
          default: lex.push_back(nlp_pkg::CH_EXP);
        endcase
        repeat ($urandom_range(0, 3))
          lex.push_back(code_t'($urandom_range(nlp_pkg::CH_0, nlp_pkg::CH_9)));
      end
    end else if (rdx == nlp_pkg::RADIX_HEX && $urandom_range(0, 9) == 0) begin
      lex.push_back(nlp_pkg::CH_EXP);
      if ($urandom_range(0, 1)) lex.push_back(nlp_pkg::CH_1);
    end

    // well formed suffix group, float mark last
    if ($urandom_range(0, 1)) begin
      suf = {};
      repeat ($urandom_range(0, 2)) suf.push_back(nlp_pkg::CH_TAH);
      if ($urandom_range(0, 1)) suf.insert($urandom_range(0, suf.size()), nlp_pkg::CH_GHAIN);
      if ($urandom_range(0, 2) == 0) suf.push_back(nlp_pkg::CH_HAH);
      foreach (suf[i]) lex.push_back(suf[i]);
    end

    // broken tail
    if ($urandom_range(0, 5) == 0) begin
      n = $urandom_range(1, 2);
      repeat (n) lex.push_back(odd_code());
    end
    if (lex.size() == 0) lex.push_back(odd_code());
  endfunction

  // stimulus
  initial begin
    lexeme_t     lex;
    int unsigned lexemes;
    sb                = new();
    steady            = 1'b0;
    chars_sent        = 0;
    lexemes           = 0;
    rst_ni            = 1'b0;
    char_ch.valid     = 1'b0;
    char_ch.char_code = '0;
    char_ch.last_char = 1'b0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // hex with mixed case digits
    lex = {nlp_pkg::CH_0, nlp_pkg::CH_LO_X, nlp_pkg::CH_UP_F, nlp_pkg::CH_LO_A};
    send_lexeme(lex);
    // binary with two long marks and an unsigned mark
    lex = {nlp_pkg::CH_0, nlp_pkg::CH_UP_B, nlp_pkg::CH_1, nlp_pkg::CH_0,
           nlp_pkg::CH_TAH, nlp_pkg::CH_GHAIN, nlp_pkg::CH_TAH};
    send_lexeme(lex);
    // arabic-indic digits with a float mark
    lex = {nlp_pkg::CH_AR9, nlp_pkg::CH_AR0, nlp_pkg::CH_HAH};
    send_lexeme(lex);
    // prefix without digits
    lex = {nlp_pkg::CH_0, nlp_pkg::CH_LO_X};
    send_lexeme(lex);
    // two separators
    lex = {nlp_pkg::CH_1, nlp_pkg::CH_DOT, nlp_pkg::CH_1, nlp_pkg::CH_ARDOT};
    send_lexeme(lex);
    // decimal exponent form
    lex = {nlp_pkg::CH_1, nlp_pkg::CH_EXP, nlp_pkg::CH_9};
    send_lexeme(lex);
    // suffix first, then a digit after the float mark
    lex = {nlp_pkg::CH_HAH, nlp_pkg::CH_1};
    send_lexeme(lex);
    // extremes of the code point range
    lex = {code_t'(21'h10FFFF)};
    send_lexeme(lex);
    lex = {code_t'(0)};
    send_lexeme(lex);
    // prefix letter not after a leading zero
    lex = {nlp_pkg::CH_9, nlp_pkg::CH_UP_X};
    send_lexeme(lex);
    // hex exponent form
    lex = {nlp_pkg::CH_0, nlp_pkg::CH_LO_X, nlp_pkg::CH_1, nlp_pkg::CH_EXP};
    send_lexeme(lex);

    // random lexemes, with one stretch free of idle cycles
    while (chars_sent < CHAR_TARGET) begin
      steady = (lexemes >= 120 && lexemes < 180);
      make_lexeme(lex);
      send_lexeme(lex);
      lexemes++;
    end
    steady        = 1'b0;
    char_ch.valid <= 1'b0;

    // drain
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (sb.fail_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
